// ===== src/cvas_pkg.sv =====
// Shared types and constants for the CAN variable access server.
`timescale 1ns / 1ps
`default_nettype none

package cvas_pkg;

    localparam int RECORDS_DEF   = 16;
    localparam int VAR_BYTES_DEF = 1024;
    localparam int MAX_PAYLOAD   = 8;

    typedef enum logic [1:0] {
        ACT_FRAME  = 2'd0,
        ACT_LOAD   = 2'd1,
        ACT_HWRITE = 2'd2,
        ACT_HREAD  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        STS_OK    = 3'd0,
        STS_LEN   = 3'd1,
        STS_RANGE = 3'd2,
        STS_NOREC = 3'd3,
        STS_HOST  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_REDUCE,
        S_XFER,
        S_HREAD,
        S_DRAIN,
        S_DONE
    } fsm_t;

    typedef struct packed {
        logic [9:0]  base;
        logic [10:0] size;
        logic        fixed;
    } rec_t;

endpackage

`default_nettype wire

// ===== src/can_variable_access_server_core.sv =====
// Frame and host access server over a record table and a byte-wide variable memory.
// One item at a time. Steps: accept, record check, address reduction by repeated
// subtraction of VAR_BYTES, then the payload bytes one by one (plus a read drain) and
// a result step; host actions reduce their address too, then write or read one byte.
// Throughput is set by the single byte port of the variable memory.
// Reset invalidates every record at once; variable memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module can_variable_access_server_core #(
    parameter int RECORDS   = cvas_pkg::RECORDS_DEF,
    parameter int VAR_BYTES = cvas_pkg::VAR_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [3:0]  record_index,
    input  wire logic [7:0]  offset,
    input  wire logic        rtr,
    input  wire logic [3:0]  length,
    input  wire logic [63:0] data,
    input  wire logic [9:0]  rec_base,
    input  wire logic [10:0] rec_size,
    input  wire logic        rec_fixed,
    input  wire logic        rec_valid,
    input  wire logic [9:0]  mem_addr,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic             reply_valid,
    output logic [3:0]       reply_length,
    output logic [63:0]      reply_data,
    output logic [7:0]       read_byte
);

    localparam int RW = (RECORDS > 1) ? $clog2(RECORDS) : 1;
    localparam int IW = 6;
    localparam int AW = $clog2(VAR_BYTES);
    localparam int CW = 18;
    localparam logic [CW-1:0] VB     = CW'(VAR_BYTES);
    localparam logic [AW-1:0] LAST   = AW'(VAR_BYTES - 1);
    localparam logic [10:0]   VB_SUB = 11'(VAR_BYTES);
    localparam logic [3:0]    MAXLEN = 4'(cvas_pkg::MAX_PAYLOAD);

    cvas_pkg::fsm_t state_reg, state_next;

    // captured item
    cvas_pkg::action_t act_reg;
    logic [3:0]  idx_reg;
    logic [7:0]  off_reg;
    logic        rtr_reg;
    logic [3:0]  len_reg;
    logic [63:0] data_reg;
    logic [9:0]  rbase_reg;
    logic [10:0] rsize_reg;
    logic        rfixed_reg;
    logic        rvalid_reg;
    logic [9:0]  maddr_reg;
    logic        hit_reg;

    // working state
    logic [10:0]   addr_reg;
    logic [AW-1:0] ptr_reg;
    logic [3:0]    cnt_reg;
    logic          rd_pend_reg;
    logic [2:0]    rd_idx_reg;

    cvas_pkg::status_t res_status_reg;
    logic        res_rv_reg;
    logic [3:0]  res_rlen_reg;
    logic [63:0] res_data_reg;
    logic [7:0]  res_rbyte_reg;

    logic        out_valid_reg;
    logic [2:0]  status_reg;
    logic        reply_valid_reg;
    logic [3:0]  reply_length_reg;
    logic [63:0] reply_data_reg;
    logic [7:0]  read_byte_reg;

    // memories
    cvas_pkg::rec_t rec_mem [RECORDS];
    cvas_pkg::rec_t rec_q_reg;
    logic [RECORDS-1:0] rec_vld_reg;
    logic [7:0] var_mem [VAR_BYTES];
    logic [7:0] mem_q_reg;

    // control
    logic accept, out_free, rec_we, mem_we;
    logic [IW-1:0] in_idx_w, reg_idx_w;
    logic [RW-1:0] rec_raddr, rec_waddr;
    logic in_idx_ok, reg_idx_ok, in_hit;
    logic [7:0]  eff_off;
    logic [8:0]  bound;
    logic        frame_ok;
    logic        addr_ge;
    logic        xfer_last;
    logic        is_read_frame;
    logic [7:0]  wr_byte;

    assign in_idx_w   = IW'(record_index);
    assign reg_idx_w  = IW'(idx_reg);
    assign rec_raddr  = in_idx_w[RW-1:0];
    assign rec_waddr  = reg_idx_w[RW-1:0];
    assign in_idx_ok  = in_idx_w < IW'(RECORDS);
    assign reg_idx_ok = reg_idx_w < IW'(RECORDS);
    assign in_hit     = in_idx_ok & rec_vld_reg[rec_raddr];

    assign eff_off  = rec_q_reg.fixed ? 8'd0 : off_reg;
    assign bound    = 9'(len_reg) + 9'(eff_off);
    assign frame_ok = hit_reg && (len_reg <= MAXLEN) && (11'(bound) <= rec_q_reg.size);
    assign addr_ge  = CW'(addr_reg) >= VB;
    assign is_read_frame = (act_reg == cvas_pkg::ACT_FRAME) && rtr_reg;
    assign xfer_last = (act_reg == cvas_pkg::ACT_HWRITE) || (4'(cnt_reg + 4'd1) == len_reg);
    assign wr_byte  = data_reg[{cnt_reg[2:0], 3'b000} +: 8];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cvas_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = cvas_pkg::S_CHECK;
            end
            cvas_pkg::S_CHECK:
            begin
                case (act_reg)
                    cvas_pkg::ACT_LOAD:  state_next = cvas_pkg::S_DONE;
                    cvas_pkg::ACT_FRAME: state_next = frame_ok ? cvas_pkg::S_REDUCE
                                                               : cvas_pkg::S_DONE;
                    default:             state_next = cvas_pkg::S_REDUCE;
                endcase
            end
            cvas_pkg::S_REDUCE:
            begin
                if (!addr_ge)
                begin
                    if (act_reg == cvas_pkg::ACT_HREAD)
                        state_next = cvas_pkg::S_HREAD;
                    else if (act_reg == cvas_pkg::ACT_FRAME && len_reg == 4'd0)
                        state_next = cvas_pkg::S_DONE;
                    else
                        state_next = cvas_pkg::S_XFER;
                end
            end
            cvas_pkg::S_XFER:
            begin
                if (xfer_last)
                    state_next = is_read_frame ? cvas_pkg::S_DRAIN : cvas_pkg::S_DONE;
            end
            cvas_pkg::S_HREAD: state_next = cvas_pkg::S_DRAIN;
            cvas_pkg::S_DRAIN: state_next = cvas_pkg::S_DONE;
            cvas_pkg::S_DONE:
            begin
                if (out_free)
                    state_next = cvas_pkg::S_IDLE;
            end
            default: state_next = cvas_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall = (state_reg != cvas_pkg::S_IDLE);
        accept   = in_valid && (state_reg == cvas_pkg::S_IDLE);
        out_free = !out_valid_reg || !out_stall;
        rec_we   = (state_reg == cvas_pkg::S_CHECK) && (act_reg == cvas_pkg::ACT_LOAD)
                   && reg_idx_ok;
        mem_we   = (state_reg == cvas_pkg::S_XFER) && !is_read_frame;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cvas_pkg::S_IDLE;
            rec_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == cvas_pkg::S_XFER) && is_read_frame;
            if (rec_we)
                rec_vld_reg[rec_waddr] <= rvalid_reg;
            if (state_reg == cvas_pkg::S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg        <= cvas_pkg::action_t'(action);
            idx_reg        <= record_index;
            off_reg        <= offset;
            rtr_reg        <= rtr;
            len_reg        <= length;
            data_reg       <= data;
            rbase_reg      <= rec_base;
            rsize_reg      <= rec_size;
            rfixed_reg     <= rec_fixed;
            rvalid_reg     <= rec_valid;
            maddr_reg      <= mem_addr;
            hit_reg        <= in_hit;
            res_status_reg <= cvas_pkg::STS_HOST;
            res_rv_reg     <= 1'b0;
            res_rlen_reg   <= 4'd0;
            res_data_reg   <= '0;
            res_rbyte_reg  <= 8'd0;
        end

        case (state_reg)
            cvas_pkg::S_CHECK:
            begin
                cnt_reg <= 4'd0;
                case (act_reg)
                    cvas_pkg::ACT_LOAD:
                    begin
                        if (!reg_idx_ok)
                            res_status_reg <= cvas_pkg::STS_NOREC;
                    end
                    cvas_pkg::ACT_FRAME:
                    begin
                        addr_reg <= 11'(rec_q_reg.base) + 11'(eff_off);
                        if (!hit_reg)
                            res_status_reg <= cvas_pkg::STS_NOREC;
                        else if (len_reg > MAXLEN)
                            res_status_reg <= cvas_pkg::STS_LEN;
                        else if (11'(bound) > rec_q_reg.size)
                            res_status_reg <= cvas_pkg::STS_RANGE;
                        else
                        begin
                            res_status_reg <= cvas_pkg::STS_OK;
                            res_rv_reg     <= rtr_reg;
                            res_rlen_reg   <= rtr_reg ? len_reg : 4'd0;
                        end
                    end
                    default: addr_reg <= 11'(maddr_reg);
                endcase
            end
            cvas_pkg::S_REDUCE:
            begin
                if (addr_ge)
                    addr_reg <= addr_reg - VB_SUB;
                else
                    ptr_reg <= AW'(addr_reg);
            end
            cvas_pkg::S_XFER:
            begin
                cnt_reg    <= cnt_reg + 4'd1;
                rd_idx_reg <= cnt_reg[2:0];
                ptr_reg    <= (ptr_reg == LAST) ? '0 : ptr_reg + AW'(1);
            end
            cvas_pkg::S_DRAIN:
            begin
                if (act_reg == cvas_pkg::ACT_HREAD)
                    res_rbyte_reg <= mem_q_reg;
            end
            default: ;
        endcase

        // read data arrives in the cycle after its address
        if (rd_pend_reg)
            res_data_reg[{rd_idx_reg, 3'b000} +: 8] <= mem_q_reg;

        if (state_reg == cvas_pkg::S_DONE && out_free)
        begin
            status_reg       <= res_status_reg;
            reply_valid_reg  <= res_rv_reg;
            reply_length_reg <= res_rlen_reg;
            reply_data_reg   <= res_data_reg;
            read_byte_reg    <= res_rbyte_reg;
        end
    end

    // record table memory
    always_ff @(posedge clk)
    begin
        if (rec_we)
            rec_mem[rec_waddr] <= '{base: rbase_reg, size: rsize_reg, fixed: rfixed_reg};
        rec_q_reg <= rec_mem[rec_raddr];
    end

    // variable byte memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            var_mem[ptr_reg] <= wr_byte;
        mem_q_reg <= var_mem[ptr_reg];
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign reply_valid  = reply_valid_reg;
    assign reply_length = reply_length_reg;
    assign reply_data   = reply_data_reg;
    assign read_byte    = read_byte_reg;

endmodule

`default_nettype wire

// ===== bench/can_variable_access_server_core_tb.sv =====
// Self-checking bench for the CAN variable access server core: frames, record loads, host access.
`timescale 1ns / 1ps

module can_variable_access_server_core_tb;

    localparam int N_REC   = cvas_pkg::RECORDS_DEF;
    localparam int N_BYTES = cvas_pkg::VAR_BYTES_DEF;
    localparam int ITEMS   = 700;

    typedef struct packed {
        cvas_pkg::action_t act;
        logic [3:0]  idx;
        logic [7:0]  off;
        logic        rtr;
        logic [3:0]  len;
        logic [63:0] data;
        logic [9:0]  base;
        logic [10:0] size;
        logic        fixed;
        logic        live;
        logic [9:0]  addr;
        logic [7:0]  gap;
        logic        drain;
    } beat_t;

    typedef struct packed {
        cvas_pkg::status_t st;
        logic        rv;
        logic [3:0]  rl;
        logic [63:0] rd;
        logic [7:0]  rb;
    } answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  action = '0;
    logic [3:0]  record_index = '0;
    logic [7:0]  offset = '0;
    logic        rtr = 1'b0;
    logic [3:0]  length = '0;
    logic [63:0] data = '0;
    logic [9:0]  rec_base = '0;
    logic [10:0] rec_size = '0;
    logic        rec_fixed = 1'b0;
    logic        rec_valid = 1'b0;
    logic [9:0]  mem_addr = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic        reply_valid;
    logic [3:0]  reply_length;
    logic [63:0] reply_data;
    logic [7:0]  read_byte;

    can_variable_access_server_core u_top (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    // predicted state of the block
    logic [7:0]  var_bytes [0:N_BYTES-1];
    logic [9:0]  tab_base  [0:N_REC-1];
    logic [10:0] tab_size  [0:N_REC-1];
    logic        tab_fixed [0:N_REC-1];
    logic        tab_live  [0:N_REC-1];

    // what the generator knows when it plans: keeps reads off unwritten bytes
    logic [9:0]  plan_base    [0:N_REC-1];
    logic [10:0] plan_size    [0:N_REC-1];
    logic        plan_fixed   [0:N_REC-1];
    logic        plan_live    [0:N_REC-1];
    bit          plan_written [0:N_BYTES-1];

    beat_t   stim_q[$];
    answer_t answer_q[$];
    beat_t   on_bus;
    int      n_sent = 0;
    int      n_done = 0;
    int      n_fail = 0;
    int      n_replies = 0;
    int      status_seen [0:4];
    int      total_beats;
    int      idle_cnt = 0;
    int      stall_left = 0;
    int      cyc = 0;
    logic    hold_off = 1'b0;
    bit      quiet_gaps = 1'b0;
    bit      drain_next = 1'b0;

    function automatic logic [7:0] pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 8'd0;
        else if (r < 85)
            return 8'($urandom_range(1, 3));
        else if (r < 96)
            return 8'($urandom_range(4, 12));
        else
            return 8'($urandom_range(20, 80));
    endfunction

    function automatic answer_t serve(beat_t b);
        answer_t a;
        int      eff_off;
        int      start;
        int      bound;
        int      i;
        a = '0;
        a.st = cvas_pkg::STS_HOST;
        case (b.act)
            cvas_pkg::ACT_FRAME:
            begin
                if (!tab_live[b.idx])
                    a.st = cvas_pkg::STS_NOREC;
                else if (b.len > cvas_pkg::MAX_PAYLOAD)
                    a.st = cvas_pkg::STS_LEN;
                else
                begin
                    eff_off = tab_fixed[b.idx] ? 0 : int'(b.off);
                    start = int'(tab_base[b.idx]) + eff_off;
                    bound = int'(b.len) + eff_off;
                    if (bound > int'(tab_size[b.idx]))
                        a.st = cvas_pkg::STS_RANGE;
                    else
                    begin
                        a.st = cvas_pkg::STS_OK;
                        for (i = 0; i < int'(b.len); i++)
                            if (b.rtr)
                                a.rd[8*i +: 8] = var_bytes[(start + i) % N_BYTES];
                            else
                                var_bytes[(start + i) % N_BYTES] = b.data[8*i +: 8];
                        if (b.rtr)
                        begin
                            a.rv = 1'b1;
                            a.rl = b.len;
                        end
                    end
                end
            end
            cvas_pkg::ACT_LOAD:
            begin
                tab_base[b.idx]  = b.base;
                tab_size[b.idx]  = b.size;
                tab_fixed[b.idx] = b.fixed;
                tab_live[b.idx]  = b.live;
            end
            cvas_pkg::ACT_HWRITE:
                var_bytes[b.addr] = b.data[7:0];
            default:
                a.rb = var_bytes[b.addr];
        endcase
        return a;
    endfunction

    function automatic beat_t filler(cvas_pkg::action_t act);
        beat_t b;
        b = '0;
        b.act   = act;
        b.idx   = 4'($urandom);
        b.off   = 8'($urandom);
        b.rtr   = 1'($urandom);
        b.len   = 4'($urandom);
        b.data  = {$urandom, $urandom};
        b.base  = 10'($urandom);
        b.size  = 11'($urandom);
        b.fixed = 1'($urandom);
        b.live  = 1'($urandom);
        b.addr  = 10'($urandom);
        return b;
    endfunction

    // Plans the beat against the generator's view and queues it. Reads that would touch
    // bytes never written are turned into writes.
    function automatic void queue_beat(beat_t b);
        int eff_off;
        int start;
        int i;
        bit fits;
        b.gap = quiet_gaps ? 8'd0 : pick_gap();
        b.drain = drain_next;
        drain_next = 1'b0;
        case (b.act)
            cvas_pkg::ACT_LOAD:
            begin
                plan_base[b.idx]  = b.base;
                plan_size[b.idx]  = b.size;
                plan_fixed[b.idx] = b.fixed;
                plan_live[b.idx]  = b.live;
            end
            cvas_pkg::ACT_HWRITE:
                plan_written[b.addr] = 1'b1;
            cvas_pkg::ACT_HREAD:
            begin
                if (!plan_written[b.addr])
                begin
                    b.act = cvas_pkg::ACT_HWRITE;
                    plan_written[b.addr] = 1'b1;
                end
            end
            default:
            begin
                eff_off = plan_fixed[b.idx] ? 0 : int'(b.off);
                start = int'(plan_base[b.idx]) + eff_off;
                fits = plan_live[b.idx] && b.len <= cvas_pkg::MAX_PAYLOAD
                       && int'(b.len) + eff_off <= int'(plan_size[b.idx]);
                if (fits && b.rtr)
                    for (i = 0; i < int'(b.len); i++)
                        if (!plan_written[(start + i) % N_BYTES])
                            b.rtr = 1'b0;
                if (fits && !b.rtr)
                    for (i = 0; i < int'(b.len); i++)
                        plan_written[(start + i) % N_BYTES] = 1'b1;
            end
        endcase
        stim_q.push_back(b);
    endfunction

    function automatic void put_frame(logic [3:0] idx, logic [7:0] off, logic rd,
                                      logic [3:0] len, logic [63:0] payload);
        beat_t b;
        b = filler(cvas_pkg::ACT_FRAME);
        b.idx  = idx;
        b.off  = off;
        b.rtr  = rd;
        b.len  = len;
        b.data = payload;
        queue_beat(b);
    endfunction

    function automatic void put_load(logic [3:0] idx, logic [9:0] base, logic [10:0] size,
                                     logic fixed, logic live);
        beat_t b;
        b = filler(cvas_pkg::ACT_LOAD);
        b.idx   = idx;
        b.base  = base;
        b.size  = size;
        b.fixed = fixed;
        b.live  = live;
        queue_beat(b);
    endfunction

    function automatic void put_hwrite(logic [9:0] addr, logic [7:0] value);
        beat_t b;
        b = filler(cvas_pkg::ACT_HWRITE);
        b.addr = addr;
        b.data[7:0] = value;
        queue_beat(b);
    endfunction

    function automatic void put_hread(logic [9:0] addr);
        beat_t b;
        b = filler(cvas_pkg::ACT_HREAD);
        b.addr = addr;
        queue_beat(b);
    endfunction

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
            n_fail++;
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin : drive
        int idle_now;
        bit took;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            idle_cnt <= 0;
        end
        else
        begin
            took = in_valid && !in_stall;
            if (took)
            begin
                answer_q.push_back(serve(on_bus));
                n_sent <= n_sent + 1;
            end
            if (!in_valid || took)
            begin
                idle_now = took ? 0 : idle_cnt;
                if (stim_q.size() > 0 && idle_now >= int'(stim_q[0].gap)
                    && !(stim_q[0].drain && n_done != n_sent + int'(took)))
                begin
                    on_bus = stim_q.pop_front();
                    in_valid     <= 1'b1;
                    action       <= on_bus.act;
                    record_index <= on_bus.idx;
                    offset       <= on_bus.off;
                    rtr          <= on_bus.rtr;
                    length       <= on_bus.len;
                    data         <= on_bus.data;
                    rec_base     <= on_bus.base;
                    rec_size     <= on_bus.size;
                    rec_fixed    <= on_bus.fixed;
                    rec_valid    <= on_bus.live;
                    mem_addr     <= on_bus.addr;
                    idle_cnt     <= 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                    idle_cnt <= idle_now + 1;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin : observe
        answer_t want;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
            cyc        <= 0;
        end
        else
        begin
            cyc <= cyc + 1;
            if (out_valid && !out_stall)
            begin
                n_done <= n_done + 1;
                if (answer_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected, status %0d", $time, status);
                    n_fail++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    check_field("status", status, want.st);
                    check_field("reply_valid", reply_valid, want.rv);
                    check_field("reply_length", reply_length, want.rl);
                    check_field("reply_data", reply_data, want.rd);
                    check_field("read_byte", read_byte, want.rb);
                    status_seen[want.st]++;
                    if (want.rv)
                        n_replies++;
                end
            end
            // one window in four runs without back-pressure
            if (hold_off)
                out_stall <= 1'b1;
            else if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (cyc[8:7] != 2'b11 && $urandom_range(0, 3) == 0)
                    stall_left <= int'(pick_gap());
            end
        end
    end

    // long receiver hold-off while the sender keeps offering, so the input backs up
    initial
    begin
        wait (n_sent >= 260);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : run
        int          k;
        int          r;
        int          sz;
        logic [3:0]  ri;
        logic [7:0]  ro;
        logic [3:0]  rl;
        bit          mid_drain;
        mid_drain = 1'b0;
        for (k = 0; k < 5; k++)
            status_seen[k] = 0;
        for (k = 0; k < N_REC; k++)
        begin
            tab_live[k]  = 1'b0;
            tab_fixed[k] = 1'b0;
            tab_base[k]  = '0;
            tab_size[k]  = '0;
            plan_live[k]  = 1'b0;
            plan_fixed[k] = 1'b0;
            plan_base[k]  = '0;
            plan_size[k]  = '0;
        end
        for (k = 0; k < N_BYTES; k++)
            plan_written[k] = 1'b0;

        // directed
        put_frame(4'd0, 8'd0, 1'b0, 4'd8, '1);                // nothing registered yet
        put_load(4'd0, 10'd0, 11'd16, 1'b0, 1'b1);
        put_load(4'd1, 10'd1020, 11'd2047, 1'b0, 1'b1);
        put_load(4'd15, 10'd1023, 11'd8, 1'b1, 1'b1);
        put_load(4'd2, 10'd1023, 11'd1024, 1'b1, 1'b0);      // empty record
        put_hwrite(10'd0, 8'hff);
        put_hwrite(10'd1023, 8'h00);
        put_hread(10'd0);
        put_frame(4'd0, 8'd0, 1'b0, 4'd8, '1);
        put_frame(4'd0, 8'd8, 1'b0, 4'd8, 64'h0123_4567_89ab_cdef);   // ends on the size
        put_frame(4'd0, 8'd9, 1'b0, 4'd8, '0);               // write past the end
        put_frame(4'd0, 8'd9, 1'b1, 4'd8, '0);               // read past the end
        put_frame(4'd0, 8'd0, 1'b1, 4'd8, '0);
        put_frame(4'd0, 8'd16, 1'b1, 4'd0, '0);              // empty reply at the bound
        put_frame(4'd0, 8'd3, 1'b0, 4'd0, '1);
        put_frame(4'd0, 8'd0, 1'b0, 4'd9, '1);
        put_frame(4'd0, 8'd0, 1'b1, 4'd15, '1);
        put_frame(4'd2, 8'd0, 1'b0, 4'd1, '1);
        put_frame(4'd1, 8'd255, 1'b0, 4'd8, 64'hfedc_ba98_7654_3210);  // wraps the memory
        put_frame(4'd1, 8'd255, 1'b1, 4'd8, '0);
        put_frame(4'd15, 8'd200, 1'b0, 4'd8, 64'h8000_0000_0000_0001); // offset ignored
        put_frame(4'd15, 8'd77, 1'b1, 4'd8, '0);
        put_hread(10'd1023);
        put_load(4'd0, 10'd0, 11'd0, 1'b0, 1'b1);
        put_frame(4'd0, 8'd0, 1'b1, 4'd0, '0);

        // random
        drain_next = 1'b1;
        while (stim_q.size() < ITEMS)
        begin
            quiet_gaps = (stim_q.size() >= 230 && stim_q.size() < 330)
                         || (stim_q.size() % 150 < 20);
            if (!mid_drain && stim_q.size() >= 450)
            begin
                drain_next = 1'b1;
                mid_drain = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                k = $urandom_range(0, 9);
                if (k < 7)
                    sz = $urandom_range(1, 64);
                else if (k < 9)
                    sz = $urandom_range(0, 1024);
                else
                    sz = $urandom_range(0, 2047);
                put_load(4'($urandom), 10'($urandom), 11'(sz),
                         1'($urandom_range(0, 3) == 0), 1'($urandom_range(0, 99) < 85));
            end
            else if (r < 18)
                put_hwrite(10'($urandom), 8'($urandom));
            else if (r < 28)
                put_hread(10'($urandom));
            else
            begin
                ri = 4'($urandom);
                repeat (3)
                    if (!plan_live[ri])
                        ri = 4'($urandom);
                rl = ($urandom_range(0, 99) < 88) ? 4'($urandom_range(0, 8))
                                                  : 4'($urandom_range(9, 15));
                if (!plan_fixed[ri] && plan_size[ri] > 0 && $urandom_range(0, 9) < 8)
                    ro = 8'($urandom_range(0, plan_size[ri] > 255 ? 255 : plan_size[ri]));
                else
                    ro = 8'($urandom);
                // half the time a write followed by its read-back
                if ($urandom_range(0, 1))
                begin
                    put_frame(ri, ro, 1'b0, rl, {$urandom, $urandom});
                    put_frame(ri, ro, 1'b1, rl, {$urandom, $urandom});
                end
                else
                    put_frame(ri, ro, 1'($urandom), rl, {$urandom, $urandom});
            end
        end
        quiet_gaps = 1'b0;
        total_beats = stim_q.size();

        repeat (11) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        wait (n_sent == total_beats && n_done >= n_sent);
        repeat (40) @(posedge clk);
        if (answer_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, answer_q.size());
            n_fail++;
        end
        $display("Covered %0d beats: %0d ok, %0d bad length, %0d out of range, %0d no record,",
                 n_sent, status_seen[cvas_pkg::STS_OK], status_seen[cvas_pkg::STS_LEN],
                 status_seen[cvas_pkg::STS_RANGE], status_seen[cvas_pkg::STS_NOREC]);
        $display("%0d host actions and %0d reply frames, with back-pressure on both sides.",
                 status_seen[cvas_pkg::STS_HOST], n_replies);
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
